### rtl/core/pfx_pkg.sv
// shared types, character codes and status codes for the postfix evaluator
// used by pfx_divider and postfix_expression_evaluator; no dependencies
package pfx_pkg;

  localparam int DEFAULT_STACK_DEPTH = 16;
  localparam int WORD_W              = 32;

  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_NINE  = 8'h39;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_STAR  = 8'h2A;
  localparam logic [7:0] SYM_SLASH = 8'h2F;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic [1:0]               status;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
  } div_rsp_t;

  // first error of an expression is kept
  function automatic logic [1:0] flag_err(logic [1:0] cur, logic [1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

### rtl/core/pfx_divider.sv
// signed 32-bit divider, truncating toward zero, one quotient bit per cycle
// depends on pfx_pkg for the request and response structs
module pfx_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  pfx_pkg::div_req_t req,
  output pfx_pkg::div_rsp_t rsp
);

  localparam int W  = pfx_pkg::WORD_W;
  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          fin_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic [W-1:0]  den_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  rem_r;

  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= CW'(W - 1);
      neg_r <= req.num[W-1] ^ req.den[W-1];
      den_r <= req.den[W-1] ? ('0 - req.den) : req.den;
      quo_r <= req.num[W-1] ? ('0 - req.num) : req.num;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      // restoring step: keep the remainder when the trial subtract goes negative
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = fin_r;
  assign rsp.quot = neg_r ? ('0 - quo_r) : quo_r;

endmodule

### rtl/core/postfix_expression_evaluator.sv
// postfix evaluator: digits and ignored characters are handled in S_IDLE, + - *
// pass S_OP and S_FIN; / with a nonzero divisor also waits in S_DIV (one
// quotient bit per cycle in pfx_divider); the stack read port is registered.
// a result word reaches the output register in the cycle after its last
// character is done. synchronous reset clears the stack count, the error and
// the output valid; the stack memory is unreset. depends on pfx_pkg, pfx_divider
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfx_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfx_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output pfx_pkg::out_word_t out_word
);

  localparam int W  = pfx_pkg::WORD_W;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OP   = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [1:0]         err_r, err_nxt;
  logic [W-1:0]       top_r, top_nxt;
  logic [W-1:0]       res_r, res_nxt;
  logic [7:0]         op_r, op_nxt;
  logic               last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  pfx_pkg::out_word_t out_word_r, out_word_nxt;

  // stack entries below the top; the top itself lives in top_r
  logic [W-1:0]       mem [STACK_DEPTH];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [W-1:0]       mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [W-1:0]       mem_q;

  logic               in_acc;
  logic               out_free;
  logic               emit;
  logic               is_digit;
  logic               is_op;
  logic [W-1:0]       prod;
  pfx_pkg::div_req_t  div_req;
  pfx_pkg::div_rsp_t  div_rsp;

  pfx_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_free = !out_valid_r || !out_stall;
  // a word that would produce a result waits for the output slot
  assign in_stall = (state_r != S_IDLE) || (!out_free && in_word.end_of_expression);
  assign in_acc   = in_valid && !in_stall;
  assign prod     = mem_q * top_r;

  always_comb begin
    is_digit = in_word.symbol inside {[pfx_pkg::SYM_ZERO:pfx_pkg::SYM_NINE]};
    is_op    = in_word.symbol inside {pfx_pkg::SYM_PLUS, pfx_pkg::SYM_MINUS,
                                      pfx_pkg::SYM_STAR, pfx_pkg::SYM_SLASH};
  end

  always_comb begin
    div_req.start = (state_r == S_OP) && (op_r == pfx_pkg::SYM_SLASH) && (top_r != '0);
    div_req.num   = mem_q;
    div_req.den   = top_r;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    top_nxt       = top_r;
    res_nxt       = res_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    out_word_nxt  = out_word_r;
    emit          = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = AW'(count_r - 1'b1);
    mem_wdata     = top_r;
    mem_re        = 1'b0;
    mem_raddr     = AW'(count_r - 2'd2);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (is_digit) begin
            if (count_r == CW'(STACK_DEPTH)) begin
              err_nxt = pfx_pkg::flag_err(err_r, pfx_pkg::ST_OVERFLOW);
            end else begin
              mem_we    = (count_r != '0);
              top_nxt   = {{(W-8){1'b0}}, in_word.symbol - pfx_pkg::SYM_ZERO};
              count_nxt = count_r + 1'b1;
            end
          end else if (is_op) begin
            if (count_r < CW'(2)) begin
              err_nxt = pfx_pkg::flag_err(err_r, pfx_pkg::ST_UNDERFLOW);
            end else begin
              mem_re    = 1'b1;
              op_nxt    = in_word.symbol;
              last_nxt  = in_word.end_of_expression;
              state_nxt = S_OP;
            end
          end
          // an operator that pops reports at the end of its write-back instead
          if (in_word.end_of_expression && state_nxt == S_IDLE) begin
            emit = 1'b1;
            if (count_nxt == '0) begin
              out_word_nxt.value  = '0;
              out_word_nxt.status = pfx_pkg::flag_err(err_nxt, pfx_pkg::ST_UNDERFLOW);
            end else begin
              out_word_nxt.value  = $signed(top_nxt);
              out_word_nxt.status = err_nxt;
            end
            count_nxt = '0;
            err_nxt   = pfx_pkg::ST_OK;
          end
        end
      end
      S_OP: begin
        state_nxt = S_FIN;
        case (op_r)
          pfx_pkg::SYM_PLUS:  res_nxt = mem_q + top_r;
          pfx_pkg::SYM_MINUS: res_nxt = mem_q - top_r;
          pfx_pkg::SYM_STAR:  res_nxt = prod[W-1:0];
          default: begin
            if (top_r == '0) begin
              res_nxt = '0;
              err_nxt = pfx_pkg::flag_err(err_r, pfx_pkg::ST_DIVZERO);
            end else begin
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.quot;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_r || out_free) begin
          top_nxt   = res_r;
          count_nxt = count_r - 1'b1;
          state_nxt = S_IDLE;
          if (last_r) begin
            emit                = 1'b1;
            out_word_nxt.value  = $signed(res_r);
            out_word_nxt.status = err_r;
            count_nxt           = '0;
            err_nxt             = pfx_pkg::ST_OK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= pfx_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    res_r      <= res_nxt;
    op_r       <= op_nxt;
    last_r     <= last_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (count_r == '0) && (err_r == pfx_pkg::ST_OK) && out_valid)
    else $error("expression end did not clear the stack");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside a division");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result word overwrote a stalled one");

endmodule
